// ----- sv/psev_pkg.sv -----
// Package for the postfix stack evaluator: sizes, request and response types,
// opcode constants and state encodings. Used by every file in the project.
package psev_pkg;

  // Data path and stack sizing.
  localparam int DATA_W      = 32;
  localparam int STACK_DEPTH = 16;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(DATA_W + 1);

  // Token opcodes; six and seven are unused and treated as no-ops.
  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_SUB    = 3'd2;
  localparam logic [2:0] OP_MUL    = 3'd3;
  localparam logic [2:0] OP_DIV    = 3'd4;
  localparam logic [2:0] OP_FINISH = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNDER   = 2'd1,
    ST_OVER    = 2'd2,
    ST_DIVZERO = 2'd3
  } status_t;

  // One token request.
  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [DATA_W-1:0] operand_value;
  } in_req_t;

  // One result.
  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    status_t                  status;
    logic                     done_res;
  } out_rsp_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_COMMIT,
    S_EMIT
  } state_t;

endpackage

// ----- sv/psev_stack_mem.sv -----
// Stack storage of the postfix evaluator: one write port and one read port
// with a registered read. Depends on psev_pkg for its sizes.
module psev_stack_mem (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [psev_pkg::ADDR_W-1:0]  wr_addr,
  input  logic [psev_pkg::DATA_W-1:0]  wr_data,
  input  logic                         rd_en,
  input  logic [psev_pkg::ADDR_W-1:0]  rd_addr,
  output logic [psev_pkg::DATA_W-1:0]  rd_data
);
  import psev_pkg::*;

  logic [DATA_W-1:0] mem [STACK_DEPTH];

  // Write port. Entries hold garbage until pushed; the depth counter keeps
  // reads below the written region.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with a registered read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/psev_divider.sv -----
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero. Depends on psev_pkg for the data width.
module psev_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [psev_pkg::DATA_W-1:0]  dividend,
  input  logic [psev_pkg::DATA_W-1:0]  divisor,
  output logic                         done,
  output logic [psev_pkg::DATA_W-1:0]  quotient
);
  import psev_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic                 neg_r, neg_nxt;
  logic [DATA_W-1:0]    den_r, den_nxt;
  logic [DATA_W-1:0]    rem_r, rem_nxt;
  logic [DATA_W-1:0]    quo_r, quo_nxt;
  logic [DATA_W:0]      rem_shift;
  logic [DATA_W:0]      rem_diff;
  logic                 neg_n;
  logic                 neg_d;

  assign neg_n     = dividend[DATA_W-1];
  assign neg_d     = divisor[DATA_W-1];
  assign rem_shift = {rem_r, quo_r[DATA_W-1]};
  assign rem_diff  = rem_shift - {1'b0, den_r};

  // Load magnitudes on start, then one restoring step per cycle.
  always_comb begin
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = DIV_CNT_W'(DATA_W);
      neg_nxt = neg_n ^ neg_d;
      den_nxt = neg_d ? (~divisor + 1'b1) : divisor;
      quo_nxt = neg_n ? (~dividend + 1'b1) : dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == DIV_CNT_W'(1));
      if (!rem_diff[DATA_W]) begin
        rem_nxt = rem_diff[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_shift[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // Data registers.
  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  // Apply the quotient sign after the last step.
  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

// ----- sv/postfix_stack_evaluator_core.sv -----
// Top level of the postfix stack evaluator: token sequencer, stack memory and
// divider. Depends on psev_pkg, psev_stack_mem and psev_divider.
//
//   Channel | Ports                          | Direction | Carries
//   --------+--------------------------------+-----------+---------------------
//   Token   | in_valid, in_ready, in_data    | in        | opcode, operand
//   Result  | out_valid, out_ready, out_data | out       | top, status, done
//
// Push, finish, error and unused tokens go from decode to emit; add, subtract
// and multiply pass through read and commit, for the registered read of the
// second stack entry, and divide also waits on the one-bit-per-cycle divider.
// The top of stack lives in a register, so each operator reads memory once.
// Reset is synchronous and active low; stack contents need no clearing.
// A stalled result waits in the output register; one more request is taken
// meanwhile and is held before its result until the register frees up.
module postfix_stack_evaluator_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  psev_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output psev_pkg::out_rsp_t out_data
);
  import psev_pkg::*;

  state_t             state_r, state_nxt;
  logic [2:0]         op_r, op_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [DATA_W-1:0]  top_r, top_nxt;
  logic [DATA_W-1:0]  val_r, val_nxt;
  out_rsp_t           res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_rsp_t           out_data_r, out_data_nxt;

  logic               mem_wr_en;
  logic [ADDR_W-1:0]  mem_wr_addr;
  logic [DATA_W-1:0]  mem_wr_data;
  logic               mem_rd_en;
  logic [ADDR_W-1:0]  mem_rd_addr;
  logic [DATA_W-1:0]  mem_rd_data;

  logic               div_start;
  logic               div_done;
  logic [DATA_W-1:0]  div_quo;

  logic [DEPTH_W-1:0] depth_m2;
  logic [ADDR_W-1:0]  sec_addr;
  logic [DATA_W-1:0]  top_or_zero;
  logic [DATA_W-1:0]  prod;
  logic               emit_load;

  // Address of the second entry, and the visible top (zero when empty).
  assign depth_m2    = depth_r - DEPTH_W'(2);
  assign sec_addr    = depth_m2[ADDR_W-1:0];
  assign top_or_zero = (depth_r == '0) ? '0 : top_r;
  assign prod        = mem_rd_data * top_r;
  assign emit_load   = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  psev_stack_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  psev_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mem_rd_data),
    .divisor  (top_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequencer: decode, read the second entry, compute, write back, emit.
  // Reads happen only on decode and writes only on push or commit, so the
  // two ports never touch the same entry in one cycle.
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    depth_nxt   = depth_r;
    top_nxt     = top_r;
    val_nxt     = val_r;
    res_nxt     = res_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = sec_addr;
    mem_wr_data = val_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = sec_addr;
    div_start   = 1'b0;
    in_ready    = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt           = in_data.opcode;
          res_nxt.done_res = 1'b0;
          res_nxt.status   = ST_OK;
          res_nxt.top_value = top_or_zero;
          state_nxt        = S_EMIT;
          case (in_data.opcode)
            OP_PUSH: begin
              if (depth_r == DEPTH_W'(STACK_DEPTH)) begin
                res_nxt.status = ST_OVER;
              end else begin
                mem_wr_en         = 1'b1;
                mem_wr_addr       = depth_r[ADDR_W-1:0];
                mem_wr_data       = in_data.operand_value;
                depth_nxt         = depth_r + 1'b1;
                top_nxt           = in_data.operand_value;
                res_nxt.top_value = in_data.operand_value;
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
              if (depth_r < DEPTH_W'(2)) begin
                res_nxt.status = ST_UNDER;
              end else if ((in_data.opcode == OP_DIV) && (top_r == '0)) begin
                res_nxt.status = ST_DIVZERO;
              end else begin
                mem_rd_en = 1'b1;
                state_nxt = S_READ;
              end
            end
            OP_FINISH: begin
              depth_nxt = '0;
              if (depth_r == '0) begin
                res_nxt.status = ST_UNDER;
              end else begin
                res_nxt.done_res = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        state_nxt = S_COMMIT;
        case (op_r)
          OP_ADD:  val_nxt = mem_rd_data + top_r;
          OP_SUB:  val_nxt = mem_rd_data - top_r;
          OP_MUL:  val_nxt = prod;
          default: begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          val_nxt   = div_quo;
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        mem_wr_en         = 1'b1;
        depth_nxt         = depth_r - 1'b1;
        top_nxt           = val_r;
        res_nxt.top_value = val_r;
        res_nxt.status    = ST_OK;
        res_nxt.done_res  = 1'b0;
        state_nxt         = S_EMIT;
      end
      S_EMIT: begin
        if (emit_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register: loads a finished result, clears when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    top_r      <= top_nxt;
    val_r      <= val_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- sv/psev_checker.sv -----
// Port-level checks for the postfix stack evaluator, bound to the top level.
// Depends on psev_pkg and postfix_stack_evaluator_core.
module psev_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input psev_pkg::out_rsp_t out_data
);
  import psev_pkg::*;

  logic [1:0] pending_r, pending_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Requests accepted whose result has not yet been taken.
  always_comb begin
    pending_nxt = pending_r;
    if (in_acc && !out_acc) begin
      pending_nxt = pending_r + 1'b1;
    end else if (!in_acc && out_acc) begin
      pending_nxt = pending_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // No result appears without an outstanding request.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("result without a request");

  // At most one request in flight besides the held result.
  a_pending_max: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != 2'd3)
    else $error("too many requests outstanding");

  // A final value is only reported with a clean status.
  a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> out_data.status == ST_OK)
    else $error("final value with error status");

  // The input is refused while the evaluator cannot take more work.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r == 2'd2 && !out_acc |-> !in_ready)
    else $error("request taken with no room");

endmodule

bind postfix_stack_evaluator_core psev_checker u_psev_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- verif/postfix_stack_evaluator_core_test.sv -----
// Self-checking testbench for postfix_stack_evaluator_core: drives token requests,
// predicts every result with a shadow stack and compares each one as it leaves.
// Depends on psev_pkg and the postfix_stack_evaluator_core RTL.
module postfix_stack_evaluator_core_test;
  import psev_pkg::*;

  localparam int TOTAL_TOKENS = 1050;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE_CYCLES = 40;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_rsp_t out_data;

  // Shadow copy of the evaluator stack.
  logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
  int                shadow_depth = 0;

  out_rsp_t pending_results [$];
  int       idle_pct = 14;
  int       sent_count = 0;
  int       checked_count = 0;
  int       done_count = 0;
  int       fail_count = 0;
  int       stall_cycles = 0;
  int       status_seen [4] = '{0, 0, 0, 0};

  postfix_stack_evaluator_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Clock with a 20 unit period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [DATA_W-1:0] stack_top();
    if (shadow_depth == 0) return '0;
    return shadow_stack[shadow_depth-1];
  endfunction

  // Apply one token to the shadow stack and return the result it should produce.
  function automatic out_rsp_t eval_token(in_req_t t);
    out_rsp_t          r;
    logic [DATA_W-1:0] a, b, v, mag_a, mag_b, q;
    r.status   = ST_OK;
    r.done_res = 1'b0;
    v = '0;
    case (t.opcode)
      OP_PUSH: begin
        if (shadow_depth >= STACK_DEPTH) begin
          r.status = ST_OVER;
        end else begin
          shadow_stack[shadow_depth] = t.operand_value;
          shadow_depth++;
        end
        r.top_value = stack_top();
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (shadow_depth < 2) begin
          r.status = ST_UNDER;
        end else begin
          b = shadow_stack[shadow_depth-1];
          a = shadow_stack[shadow_depth-2];
          case (t.opcode)
            OP_ADD: v = a + b;
            OP_SUB: v = a - b;
            OP_MUL: v = a * b;
            default: begin
              if (b == '0) begin
                r.status = ST_DIVZERO;
              end else begin
                // Divide magnitudes, then fix the sign: truncation toward zero.
                mag_a = a[DATA_W-1] ? -a : a;
                mag_b = b[DATA_W-1] ? -b : b;
                q = mag_a / mag_b;
                v = (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
              end
            end
          endcase
          if (r.status == ST_OK) begin
            shadow_depth--;
            shadow_stack[shadow_depth-1] = v;
          end
        end
        r.top_value = stack_top();
      end
      OP_FINISH: begin
        if (shadow_depth == 0) begin
          r.status    = ST_UNDER;
          r.top_value = '0;
        end else begin
          r.top_value = stack_top();
          r.done_res  = 1'b1;
        end
        shadow_depth = 0;
      end
      default: r.top_value = stack_top();
    endcase
    return r;
  endfunction

  // Operand values lean toward the corners of the signed range.
  function automatic logic [DATA_W-1:0] rand_operand();
    case ($urandom_range(7))
      0: return {1'b1, {(DATA_W-1){1'b0}}};
      1: return {1'b0, {(DATA_W-1){1'b1}}};
      2: return '0;
      3: return '1;
      4: return DATA_W'($urandom_range(20)) - DATA_W'(10);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Send one token request and record its predicted result once accepted.
  task automatic send_token(input logic [2:0] op, input logic [DATA_W-1:0] val);
    in_req_t req;
    req.opcode        = op;
    req.operand_value = val;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(eval_token(req));
    sent_count++;
  endtask

  // Mostly well-formed expressions with random content, plus some noise tokens.
  task automatic run_expressions(input int count);
    int               pick;
    logic [2:0]       op;
    logic [DATA_W-1:0] val;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      val  = rand_operand();
      if (pick < 6) begin
        op = 3'($urandom_range(7));
      end else if (shadow_depth < 2) begin
        op = (pick < 14) ? OP_FINISH : OP_PUSH;
      end else if (pick < 50) begin
        op = OP_PUSH;
      end else if (pick < 90) begin
        op = OP_ADD + 3'($urandom_range(3));
      end else begin
        op = OP_FINISH;
      end
      send_token(op, val);
    end
  endtask

  // Underflow, wraparound, divide corner cases and unused opcodes.
  task automatic test_error_cases();
    send_token(OP_FINISH, DATA_W'($urandom));
    send_token(OP_ADD, DATA_W'($urandom));
    send_token(OP_PUSH, 32'h7fff_ffff);
    send_token(OP_SUB, DATA_W'($urandom));
    send_token(OP_PUSH, 32'd1);
    send_token(OP_ADD, DATA_W'($urandom));
    send_token(OP_PUSH, 32'hffff_ffff);
    send_token(OP_DIV, DATA_W'($urandom));
    send_token(OP_PUSH, 32'd0);
    send_token(OP_DIV, DATA_W'($urandom));
    send_token(OP_SPARE6, DATA_W'($urandom));
    send_token(OP_SPARE7, DATA_W'($urandom));
    send_token(OP_MUL, DATA_W'($urandom));
    send_token(OP_PUSH, 32'h8000_0000);
    send_token(OP_SUB, DATA_W'($urandom));
    send_token(OP_PUSH, -32'sd7);
    send_token(OP_PUSH, 32'd2);
    send_token(OP_DIV, DATA_W'($urandom));
    send_token(OP_FINISH, DATA_W'($urandom));
  endtask

  // Fill the stack, push once more for overflow, then finish with a full stack.
  task automatic test_full_stack();
    while (shadow_depth < STACK_DEPTH) send_token(OP_PUSH, rand_operand());
    send_token(OP_PUSH, rand_operand());
    send_token(OP_FINISH, rand_operand());
  endtask

  // Random expressions with no idle gaps on the token side and no result stalls.
  task automatic test_back_to_back();
    idle_pct = 0;
    run_expressions(250);
    idle_pct = 14;
  endtask

  // Random expressions with gaps and stalls on both sides.
  task automatic test_random_expressions();
    run_expressions(TOTAL_TOKENS - sent_count);
  endtask

  // Stall the result channel at random and compare each accepted result.
  always @(posedge clk) begin
    out_rsp_t want;
    out_ready <= ($urandom_range(99) >= idle_pct);
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none pending, actual top %0d status %0d done %0b",
                 $time, out_data.top_value, out_data.status, out_data.done_res);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (out_data.top_value !== want.top_value) begin
          $display("%0t: top_value expected %0d actual %0d",
                   $time, want.top_value, out_data.top_value);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, want.status, out_data.status);
          fail_count++;
        end
        if (out_data.done_res !== want.done_res) begin
          $display("%0t: done_res expected %0b actual %0b",
                   $time, want.done_res, out_data.done_res);
          fail_count++;
        end
        status_seen[want.status]++;
        if (want.done_res) done_count++;
      end
    end
  end

  // Watchdog on cycles where neither channel moves a request.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results still pending",
                 $time, stall_cycles, pending_results.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_error_cases();
    test_full_stack();
    test_back_to_back();
    test_random_expressions();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) fail_count++;
    $display("Sent %0d tokens, checked %0d results, %0d completed expressions.",
             sent_count, checked_count, done_count);
    $display("Outcomes: %0d ok, %0d underflow, %0d overflow, %0d divide by zero.",
             status_seen[ST_OK], status_seen[ST_UNDER], status_seen[ST_OVER],
             status_seen[ST_DIVZERO]);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/psev_pkg.sv
sv/psev_stack_mem.sv
sv/psev_divider.sv
sv/postfix_stack_evaluator_core.sv
sv/psev_checker.sv
verif/postfix_stack_evaluator_core_test.sv
